// ===== src/masked_distinct_value_counter_top_macros.svh =====
// Assertion macros used by the top module of the distinct value counter.
`ifndef MASKED_DISTINCT_VALUE_COUNTER_TOP_MACROS_SVH
`define MASKED_DISTINCT_VALUE_COUNTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define MDVC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("distinct value counter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MDVC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("distinct value counter assertion failed");

`else

`define MDVC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MDVC_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== src/mdvc_pkg.sv =====
package mdvc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int EPOCH_W     = 8;

    localparam int VALUE_W       = 64;
    localparam int WIDTH_W       = 7;
    localparam int COUNT_OUT_W   = 11;
    localparam int WIDTH_RESET   = 32;
    localparam int CFG_ADDR_W    = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_MASK      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ELEMENT_WIDTH = 1'd1;

    // Multiplicative hash: low product, fold, then bits [63:16] reduced to a slot.
    localparam logic [VALUE_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int HASH_FOLD     = 29;
    localparam int SLOT_SHIFT    = 16;
    localparam int DIGIT_W       = 16;
    localparam int MULT_CHUNKS   = VALUE_W / DIGIT_W;
    localparam int Q_W           = VALUE_W - SLOT_SHIFT;
    localparam int MOD_BITS      = 4;
    localparam int MOD_CYCLES    = Q_W / MOD_BITS;
    localparam int STEP_W        = $clog2(MOD_CYCLES);
    localparam bit DEPTH_POW2    = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

    typedef logic [IDX_W-1:0]   slot_t;
    typedef logic [EPOCH_W-1:0] epoch_t;
    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic  done;
        slot_t slot;
    } hash_rsp_t;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        slot_t  addr;
        epoch_t wr_tag;
        value_t wr_value;
    } tbl_req_t;

    typedef struct packed {
        epoch_t tag;
        value_t value;
    } tbl_entry_t;

endpackage

// ===== src/mdvc_hash.sv =====
module mdvc_hash (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  mdvc_pkg::value_t   value,
    output mdvc_pkg::hash_rsp_t rsp
);
    import mdvc_pkg::*;

    localparam logic [1:0] HS_IDLE = 2'd0;
    localparam logic [1:0] HS_MULT = 2'd1;
    localparam logic [1:0] HS_FOLD = 2'd2;
    localparam logic [1:0] HS_MOD  = 2'd3;

    localparam logic [IDX_W:0] MOD_D = (IDX_W + 1)'(TABLE_DEPTH);

    logic [1:0]        phase_reg;
    logic [STEP_W-1:0] step_reg;
    value_t            v_reg;
    value_t            k_reg;
    value_t            acc_reg;
    logic [Q_W-1:0]    q_reg;
    slot_t             r_reg;
    logic              done_reg;
    slot_t             slot_reg;

    value_t            prod;
    value_t            folded;
    logic [IDX_W:0]    t;
    slot_t             r_mod;

    // One 16-bit digit of the value per cycle; k_reg carries the digit's weight.
    assign prod   = {{(VALUE_W - DIGIT_W){1'b0}}, v_reg[DIGIT_W-1:0]} * k_reg;
    assign folded = acc_reg ^ (acc_reg >> HASH_FOLD);

    // Long division remainder, MOD_BITS quotient bits per cycle.
    always_comb begin
        r_mod = r_reg;
        t     = '0;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {r_mod, q_reg[Q_W-1-i]};
            if (t >= MOD_D) begin
                t = t - MOD_D;
            end
            r_mod = t[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= HS_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                HS_IDLE: begin
                    if (start) begin
                        phase_reg <= HS_MULT;
                        step_reg  <= '0;
                    end
                end
                HS_MULT: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MULT_CHUNKS - 1)) begin
                        phase_reg <= HS_FOLD;
                    end
                end
                HS_FOLD: begin
                    step_reg <= '0;
                    if (DEPTH_POW2) begin
                        done_reg  <= 1'b1;
                        phase_reg <= HS_IDLE;
                    end else begin
                        phase_reg <= HS_MOD;
                    end
                end
                HS_MOD: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MOD_CYCLES - 1)) begin
                        done_reg  <= 1'b1;
                        phase_reg <= HS_IDLE;
                    end
                end
                default: begin
                    phase_reg <= HS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            HS_IDLE: begin
                v_reg   <= value;
                k_reg   <= HASH_MULT;
                acc_reg <= '0;
            end
            HS_MULT: begin
                acc_reg <= acc_reg + prod;
                v_reg   <= v_reg >> DIGIT_W;
                k_reg   <= k_reg << DIGIT_W;
            end
            HS_FOLD: begin
                q_reg    <= folded[VALUE_W-1:SLOT_SHIFT];
                r_reg    <= '0;
                slot_reg <= folded[SLOT_SHIFT +: IDX_W];
            end
            HS_MOD: begin
                q_reg    <= q_reg << MOD_BITS;
                r_reg    <= r_mod;
                slot_reg <= r_mod;
            end
            default: begin
                r_reg <= r_reg;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.slot = slot_reg;

endmodule

// ===== src/mdvc_table.sv =====
module mdvc_table (
    input  logic                 aclk,
    input  mdvc_pkg::tbl_req_t   req,
    output mdvc_pkg::tbl_entry_t rd_entry
);
    import mdvc_pkg::*;

    tbl_entry_t mem [TABLE_DEPTH];
    tbl_entry_t rd_entry_reg;

    // Single port: the controller never reads and writes in the same cycle.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= '{tag: req.wr_tag, value: req.wr_value};
        end
        if (req.rd_en) begin
            rd_entry_reg <= mem[req.addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== src/masked_distinct_value_counter_top.sv =====
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_tvalid/s_tready  | s_tdata value, s_tuser mask_bit, start_new
// m_        | out       | m_tvalid/m_tready  | m_tdata distinct_count, was_new, table_full
// cfg_      | in        | cfg_wr_en          | cfg_addr register index, cfg_wdata
//
// An included item is hashed by the 16-bit-digit multiplier, then by the remainder unit when
// TABLE_DEPTH is not a power of two, and is probed through the single table RAM port (read,
// then compare and write) for each probe; a skipped item goes straight to its result.
// After reset, and on every 255th start of an array, a clearing pass writes every table entry
// while s_tready is low. A stalled m_tready holds one finished item
// in the output register; the next item is taken and worked on until its result is due.
module masked_distinct_value_counter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // [63:0] value
    input  logic [1:0]                          s_tuser,   // [0] mask_bit, [1] start_new
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [10:0] distinct_count,
                                                           // [11] was_new, [12] table_full
    input  logic                                cfg_wr_en,
    input  logic [mdvc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mdvc_pkg::WIDTH_W-1:0]        cfg_wdata
);
    `include "masked_distinct_value_counter_top_macros.svh"
    import mdvc_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CLEAR     = 3'd1;
    localparam logic [2:0] ST_HASH_GO   = 3'd2;
    localparam logic [2:0] ST_HASH_WAIT = 3'd3;
    localparam logic [2:0] ST_PROBE_RD  = 3'd4;
    localparam logic [2:0] ST_PROBE_CHK = 3'd5;
    localparam logic [2:0] ST_RESULT    = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               use_mask_reg;
    logic [WIDTH_W-1:0] element_width_reg;
    epoch_t             epoch_reg, epoch_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    slot_t              clr_addr_reg, clr_addr_next;
    slot_t              slot_reg, slot_next;
    slot_t              probe_cnt_reg, probe_cnt_next;
    logic               pend_reg, pend_next;
    logic               incl_reg, incl_next;
    logic               new_reg, new_next;
    logic               full_reg, full_next;
    value_t             value_reg, value_next;

    logic                   m_tvalid_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_new_reg;
    logic                   out_full_reg;

    value_t     cut_mask;
    value_t     value_cut;
    logic       width_all;
    logic       accept;
    logic       slot_empty;
    logic       slot_match;
    logic       full_hit;
    logic       out_free;
    hash_rsp_t  hash_rsp;
    tbl_req_t   tbl_req;
    tbl_entry_t rd_entry;

    // Width 0 or anything from 64 up compares the whole value.
    assign width_all = (element_width_reg == '0) || (element_width_reg >= WIDTH_W'(VALUE_W));
    assign cut_mask  = width_all ? '1 : ~({VALUE_W{1'b1}} << element_width_reg[5:0]);
    assign value_cut = s_tdata & cut_mask;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // An entry counts only when its tag matches the current array's epoch.
    assign slot_empty = (rd_entry.tag != epoch_reg);
    assign slot_match = !slot_empty && (rd_entry.value == value_reg);
    assign full_hit   = !slot_empty && !slot_match
                        && (probe_cnt_reg == IDX_W'(TABLE_DEPTH - 1));

    mdvc_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_HASH_GO),
        .value   (value_reg),
        .rsp     (hash_rsp)
    );

    mdvc_table u_table (
        .aclk     (aclk),
        .req      (tbl_req),
        .rd_entry (rd_entry)
    );

    always_comb begin
        tbl_req          = '0;
        tbl_req.addr     = slot_reg;
        tbl_req.wr_tag   = epoch_reg;
        tbl_req.wr_value = value_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                tbl_req.wr_en    = 1'b1;
                tbl_req.addr     = clr_addr_reg;
                tbl_req.wr_tag   = '0;
            end
            ST_PROBE_RD: begin
                tbl_req.rd_en = 1'b1;
            end
            ST_PROBE_CHK: begin
                tbl_req.wr_en = slot_empty;
            end
            default: begin
                tbl_req.rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        pend_next      = pend_reg;
        incl_next      = incl_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        value_next     = value_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    value_next = value_cut;
                    incl_next  = !(use_mask_reg && !s_tuser[0]);
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    if (s_tuser[1]) begin
                        count_next = '0;
                    end
                    priority if (s_tuser[1] && (epoch_reg == '1)) begin
                        // Tags would wrap: wipe the table and restart the epochs.
                        pend_next     = 1'b1;
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        if (s_tuser[1]) begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        state_next = !(use_mask_reg && !s_tuser[0]) ? ST_HASH_GO : ST_RESULT;
                    end
                end
            end
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    epoch_next = EPOCH_W'(1);
                    pend_next  = 1'b0;
                    priority if (!pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (incl_reg) begin
                        state_next = ST_HASH_GO;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_HASH_GO: begin
                state_next = ST_HASH_WAIT;
            end
            ST_HASH_WAIT: begin
                if (hash_rsp.done) begin
                    slot_next      = hash_rsp.slot;
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
                priority if (slot_empty) begin
                    count_next = count_reg + 1'b1;
                    new_next   = 1'b1;
                    state_next = ST_RESULT;
                end else if (slot_match) begin
                    state_next = ST_RESULT;
                end else if (full_hit) begin
                    full_next  = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                    slot_next      = (slot_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                           : slot_reg + 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            epoch_reg     <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_mask_reg      <= 1'b0;
            element_width_reg <= WIDTH_W'(WIDTH_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_USE_MASK:      use_mask_reg      <= cfg_wdata[0];
                CFG_ELEMENT_WIDTH: element_width_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        incl_reg      <= incl_next;
        new_reg       <= new_next;
        full_reg      <= full_next;
        value_reg     <= value_next;
        if (state_reg == ST_RESULT && out_free) begin
            out_count_reg <= COUNT_OUT_W'(count_reg);
            out_new_reg   <= new_reg;
            out_full_reg  <= full_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_full_reg, out_new_reg, out_count_reg};

    `MDVC_ASSERT_IMP(a_full_only_when_packed, aclk, aresetn,
        state_reg == ST_PROBE_CHK && full_hit, count_reg == COUNT_W'(TABLE_DEPTH))
    `MDVC_ASSERT_NXT(a_insert_bumps_count, aclk, aresetn,
        state_reg == ST_PROBE_CHK && slot_empty,
        count_reg == $past(count_reg) + COUNT_W'(1))
    `MDVC_ASSERT_IMP(a_hash_done_in_wait, aclk, aresetn,
        hash_rsp.done, state_reg == ST_HASH_WAIT)
    `MDVC_ASSERT_IMP(a_live_write_tag, aclk, aresetn,
        tbl_req.wr_en && state_reg != ST_CLEAR,
        tbl_req.wr_tag == epoch_reg && epoch_reg != '0)
    `MDVC_ASSERT_IMP(a_count_bounded, aclk, aresetn,
        state_reg != ST_CLEAR, count_reg <= COUNT_W'(TABLE_DEPTH))

endmodule

// ===== tb/tb_masked_distinct_value_counter_top.sv =====
module tb_masked_distinct_value_counter_top;
    import mdvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   was_new;
        logic                   full;
    } distinct_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [WIDTH_W-1:0]    cfg_wdata = '0;

    // Shadow copy of the hash set and of the configuration.
    value_t         set_vals [TABLE_DEPTH];
    bit             set_used [TABLE_DEPTH];
    int unsigned    set_count;
    bit             cfg_use_mask;
    logic [6:0]     cfg_elem_width;

    distinct_result_t counts_due[$];
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    int               mismatches = 0;
    int               quiet_cycles = 0;

    masked_distinct_value_counter_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Inserts one element into the shadow set and returns the result it must produce.
    function automatic distinct_result_t insert_element(value_t raw, bit incl, bit start);
        value_t           v;
        logic [63:0]      h;
        int unsigned      slot;
        bit               done;
        distinct_result_t r;
        r = '0;
        if (cfg_elem_width == 0 || cfg_elem_width >= 64) begin
            v = raw;
        end else begin
            v = raw & ((64'd1 << cfg_elem_width) - 64'd1);
        end
        if (start) begin
            foreach (set_used[i]) set_used[i] = 1'b0;
            set_count = 0;
        end
        if (!(cfg_use_mask && !incl)) begin
            h = v * HASH_MULT;
            h = h ^ (h >> HASH_FOLD);
            slot = 32'((h >> SLOT_SHIFT) % 64'(TABLE_DEPTH));
            done = 1'b0;
            for (int p = 0; p < TABLE_DEPTH && !done; p++) begin
                if (!set_used[slot]) begin
                    set_vals[slot] = v;
                    set_used[slot] = 1'b1;
                    set_count++;
                    r.was_new = 1'b1;
                    done = 1'b1;
                end else if (set_vals[slot] == v) begin
                    done = 1'b1;
                end else begin
                    slot = (slot + 1) % TABLE_DEPTH;
                end
            end
            // Probed every slot without a hit or a free one: the value is dropped.
            if (!done) r.full = 1'b1;
        end
        r.count = COUNT_OUT_W'(set_count);
        return r;
    endfunction

    task automatic send_item(value_t v, bit incl, bit start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= {start, incl};
        do @(posedge aclk); while (!s_tready);
        counts_due.push_back(insert_element(v, incl, start));
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (counts_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [WIDTH_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        if (addr == CFG_USE_MASK) begin
            cfg_use_mask = data[0];
        end else begin
            cfg_elem_width = data;
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct = 23;
        recv_idle_pct = 88;
        wait_idle();
        // Default width is 32, so values that differ only above bit 31 collide.
        send_item(64'h0, 1'b1, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(64'h1_0000_0000, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(64'hDEAD_BEEF_0000_0001, 1'b1, 1'b1);
        wait_idle();
        write_reg(CFG_USE_MASK, 7'd1);
        send_item(64'd5, 1'b0, 1'b0);
        send_item(64'd5, 1'b1, 1'b0);
        // A start on a skipped element still empties the set.
        send_item(64'd7, 1'b0, 1'b1);
        send_item(64'd7, 1'b1, 1'b0);
        wait_idle();
        // Width zero compares all 64 bits.
        write_reg(CFG_ELEMENT_WIDTH, 7'd0);
        send_item(64'h0, 1'b1, 1'b1);
        send_item(64'h1_0000_0000, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd127);
        send_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        send_item(64'h1_0000_0000, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd1);
        send_item(64'd2, 1'b1, 1'b1);
        send_item(64'd3, 1'b1, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd8);
        send_item(64'h1FF, 1'b1, 1'b1);
        wait_idle();
        // Width widened inside the array: the stored value keeps its old cut.
        write_reg(CFG_ELEMENT_WIDTH, 7'd16);
        send_item(64'h1FF, 1'b1, 1'b0);
        send_item(64'hFF, 1'b1, 1'b0);
        send_item(64'h101FF, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd65);
        send_item(64'hF000_0000_0000_0000, 1'b1, 1'b1);
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd64);
        send_item(64'hF000_0000_0000_0000, 1'b1, 1'b0);
        send_item(64'h7000_0000_0000_0000, 1'b1, 1'b0);
    endtask

    task automatic test_random_mix(int n_items, int unsigned s_pct, int unsigned r_pct);
        value_t      pool [24];
        value_t      v;
        int unsigned k;
        logic [6:0]  w;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0: w = 7'd0;
                    1: w = 7'd1;
                    2: w = 7'd8;
                    3: w = 7'd16;
                    4: w = 7'd32;
                    5: w = 7'd64;
                    6: w = 7'd11;
                    7: w = 7'd127;
                    default: w = 7'($urandom_range(1, 127));
                endcase
                write_reg(CFG_ELEMENT_WIDTH, w);
                write_reg(CFG_USE_MASK, 7'($urandom_range(0, 1)));
                foreach (pool[j]) pool[j] = {$urandom, $urandom};
            end
            k = $urandom_range(0, 9);
            if (k < 6) begin
                v = pool[$urandom_range(0, 23)];
                // Noise in the upper half still matches once the value is cut narrow.
                if ($urandom_range(0, 1)) v[63:32] = v[63:32] ^ $urandom;
            end else if (k < 9) begin
                v = {$urandom, $urandom};
            end else begin
                v = $urandom_range(0, 1) ? '1 : '0;
            end
            send_item(v, 1'($urandom_range(0, 1)), $urandom_range(0, 39) == 0);
        end
    endtask

    // Frequent starts drive the block through many array epochs and its clearing passes.
    task automatic test_array_restarts(int n_items);
        send_idle_pct = 88;
        recv_idle_pct = 23;
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd8);
        write_reg(CFG_USE_MASK, 7'd1);
        for (int i = 0; i < n_items; i++) begin
            send_item({$urandom, 28'($urandom), 4'($urandom_range(0, 15))},
                      1'($urandom_range(0, 3) != 0), $urandom_range(0, 2) != 0);
        end
    endtask

    task automatic test_full_table();
        value_t base;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_idle();
        write_reg(CFG_ELEMENT_WIDTH, 7'd64);
        write_reg(CFG_USE_MASK, 7'd0);
        base = {$urandom, $urandom};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == TABLE_DEPTH / 2) wait_idle();
            send_item(base + value_t'(i), 1'($urandom_range(0, 1)), i == 0);
        end
        // The table is now full: new values are dropped, known ones are still found.
        for (int j = 0; j < 16; j++) begin
            if (j % 2 == 0) begin
                send_item(base + value_t'(TABLE_DEPTH + j), 1'b1, 1'b0);
            end else begin
                send_item(base + value_t'($urandom_range(0, TABLE_DEPTH - 1)), 1'b0, 1'b0);
            end
        end
        send_item(base, 1'b1, 1'b1);
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        distinct_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (counts_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = counts_due.pop_front();
                report_field("distinct_count", want.count, m_tdata[10:0]);
                report_field("was_new", want.was_new, m_tdata[11]);
                report_field("table_full", want.full, m_tdata[12]);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (set_used[i]) set_used[i] = 1'b0;
        set_count      = 0;
        cfg_use_mask   = 1'b0;
        cfg_elem_width = 7'(WIDTH_RESET);
        send_idle_pct  = 23;
        recv_idle_pct  = 88;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix(170, 23, 88);
        test_random_mix(170, 88, 23);
        test_array_restarts(500);
        test_full_table();
        test_random_mix(100, 0, 0);

        wait_idle();
        repeat (48) @(posedge aclk);
        if (mismatches == 0 && counts_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
